// ===== hw/rtl/bbbp_pkg.sv =====
package bbbp_pkg;

    localparam int W_SAMPLE = 16;            // audio sample
    localparam int W_SIG    = 32;            // internal signal, 8 bits below sample LSB
    localparam int W_GAIN   = 17;            // unsigned Q1.16 forward gain
    localparam int W_COEF   = 18;            // signed Q2.16 coefficient
    localparam int W_PROD   = W_SIG + W_COEF;
    localparam int W_ACC    = W_PROD + 3;    // sums of products, headroom for 2*b0*x - a1*y
    localparam int SIG_FRAC = 8;
    localparam int COEF_FRAC = 16;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = W_COEF;

    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_HP_GAIN = 3'd0,
        CFG_HP_FB1  = 3'd1,
        CFG_HP_FB2  = 3'd2,
        CFG_LP_GAIN = 3'd3,
        CFG_LP_FB1  = 3'd4,
        CFG_LP_FB2  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HP_Y,
        ST_HP_A1,
        ST_HP_D1,
        ST_HP_D2,
        ST_LP_Y,
        ST_LP_A1,
        ST_LP_D1,
        ST_LP_D2
    } t_state;

    // datapath operations; OP_D2 on the highpass also starts the lowpass b0*x product
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_Y,
        OP_A1,
        OP_D1,
        OP_D2
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel_lp;
    } t_dp_cmd;

endpackage

// ===== hw/rtl/bbbp_ctrl.sv =====
module bbbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bbbp_pkg::t_dp_cmd o_cmd
);

    bbbp_pkg::t_state r_state;
    bbbp_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    // output word register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbbp_pkg::ST_IDLE:  if (i_in_valid) n_state = bbbp_pkg::ST_HP_Y;
            bbbp_pkg::ST_HP_Y:  n_state = bbbp_pkg::ST_HP_A1;
            bbbp_pkg::ST_HP_A1: n_state = bbbp_pkg::ST_HP_D1;
            bbbp_pkg::ST_HP_D1: n_state = bbbp_pkg::ST_HP_D2;
            bbbp_pkg::ST_HP_D2: n_state = bbbp_pkg::ST_LP_Y;
            bbbp_pkg::ST_LP_Y:  n_state = bbbp_pkg::ST_LP_A1;
            bbbp_pkg::ST_LP_A1: n_state = bbbp_pkg::ST_LP_D1;
            bbbp_pkg::ST_LP_D1: n_state = bbbp_pkg::ST_LP_D2;
            bbbp_pkg::ST_LP_D2: if (out_free) n_state = bbbp_pkg::ST_IDLE;
            default:            n_state = bbbp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op     = bbbp_pkg::OP_NONE;
        o_cmd.sel_lp = 1'b0;
        o_in_stall   = 1'b1;
        n_out_valid  = r_out_valid && i_out_stall;
        unique case (r_state)
            bbbp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_cmd.op = bbbp_pkg::OP_LOAD;
            end
            bbbp_pkg::ST_HP_Y:  o_cmd.op = bbbp_pkg::OP_Y;
            bbbp_pkg::ST_HP_A1: o_cmd.op = bbbp_pkg::OP_A1;
            bbbp_pkg::ST_HP_D1: o_cmd.op = bbbp_pkg::OP_D1;
            bbbp_pkg::ST_HP_D2: o_cmd.op = bbbp_pkg::OP_D2;
            bbbp_pkg::ST_LP_Y: begin
                o_cmd.op     = bbbp_pkg::OP_Y;
                o_cmd.sel_lp = 1'b1;
            end
            bbbp_pkg::ST_LP_A1: begin
                o_cmd.op     = bbbp_pkg::OP_A1;
                o_cmd.sel_lp = 1'b1;
            end
            bbbp_pkg::ST_LP_D1: begin
                o_cmd.op     = bbbp_pkg::OP_D1;
                o_cmd.sel_lp = 1'b1;
            end
            bbbp_pkg::ST_LP_D2: begin
                o_cmd.sel_lp = 1'b1;
                if (out_free) begin
                    o_cmd.op    = bbbp_pkg::OP_D2;
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd.op = bbbp_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbbp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/bbbp_dp.sv =====
module bbbp_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bbbp_pkg::t_dp_cmd                       i_cmd,
    input  logic signed [bbbp_pkg::W_SAMPLE-1:0]    i_sample_in,
    input  logic                                    i_cfg_we,
    input  logic [bbbp_pkg::W_CFG_IDX-1:0]          i_cfg_index,
    input  logic [bbbp_pkg::W_CFG_DATA-1:0]         i_cfg_data,
    output logic signed [bbbp_pkg::W_SAMPLE-1:0]    o_sample_out,
    output logic                                    o_clipped
);

    localparam int W_ACC = bbbp_pkg::W_ACC;
    localparam int W_SIG = bbbp_pkg::W_SIG;
    localparam int W_OUT = W_SIG + 1;

    localparam logic signed [W_ACC-1:0] ACC_HALF = W_ACC'(1) <<< (bbbp_pkg::COEF_FRAC - 1);
    localparam logic signed [W_ACC-1:0] SIG_MAX  = {{(W_ACC-W_SIG+1){1'b0}}, {(W_SIG-1){1'b1}}};
    localparam logic signed [W_ACC-1:0] SIG_MIN  = {{(W_ACC-W_SIG+1){1'b1}}, {(W_SIG-1){1'b0}}};
    localparam logic signed [W_OUT-1:0] OUT_HALF = W_OUT'(1) <<< (bbbp_pkg::SIG_FRAC - 1);
    localparam logic signed [W_OUT-1:0] OUT_MAX  =
        {{(W_OUT-bbbp_pkg::W_SAMPLE+1){1'b0}}, {(bbbp_pkg::W_SAMPLE-1){1'b1}}};
    localparam logic signed [W_OUT-1:0] OUT_MIN  =
        {{(W_OUT-bbbp_pkg::W_SAMPLE+1){1'b1}}, {(bbbp_pkg::W_SAMPLE-1){1'b0}}};

    // coefficients and delay line
    logic        [bbbp_pkg::W_GAIN-1:0] r_hp_gain, r_lp_gain;
    logic signed [bbbp_pkg::W_COEF-1:0] r_hp_fb1, r_hp_fb2, r_lp_fb1, r_lp_fb2;
    logic signed [W_SIG-1:0]            r_hp_d1, r_hp_d2, r_lp_d1, r_lp_d2;

    // working registers
    logic signed [bbbp_pkg::W_PROD-1:0] r_prod;
    logic signed [bbbp_pkg::W_PROD-1:0] r_p0;
    logic signed [W_SIG-1:0]            r_y;
    logic                               r_flag;
    logic signed [bbbp_pkg::W_SAMPLE-1:0] r_sample_out;
    logic                               r_clipped;

    logic signed [W_SIG-1:0]            mul_a;
    logic signed [bbbp_pkg::W_COEF-1:0] mul_b;
    logic signed [bbbp_pkg::W_PROD-1:0] mul_p;
    logic                               prod_we;

    logic signed [W_SIG-1:0]            d1_cur, d2_cur;
    logic signed [W_ACC-1:0]            sum_y, sum_d1, sum_d2, t_d1, p0_x2;
    logic signed [W_SIG-1:0]            y_sat, d1_sat, d2_sat;
    logic                               y_ovf, d1_ovf, d2_ovf;
    logic signed [W_OUT-1:0]            out_rnd;
    logic signed [bbbp_pkg::W_SAMPLE-1:0] out_sat;
    logic                               out_ovf;

    function automatic logic signed [W_ACC-1:0] rnd16(input logic signed [W_ACC-1:0] v);
        logic signed [W_ACC-1:0] t;
        t = v + ACC_HALF;
        return t >>> bbbp_pkg::COEF_FRAC;
    endfunction

    function automatic logic signed [W_SIG-1:0] sat32(input logic signed [W_ACC-1:0] v);
        logic signed [W_SIG-1:0] r;
        if (v > SIG_MAX) begin
            r = SIG_MAX[W_SIG-1:0];
        end else if (v < SIG_MIN) begin
            r = SIG_MIN[W_SIG-1:0];
        end else begin
            r = v[W_SIG-1:0];
        end
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [W_ACC-1:0] v);
        return (v > SIG_MAX) || (v < SIG_MIN);
    endfunction

    // shared multiplier
    always_comb begin
        mul_a   = r_y;
        mul_b   = '0;
        prod_we = 1'b0;
        unique case (i_cmd.op)
            bbbp_pkg::OP_LOAD: begin
                mul_a   = W_SIG'($signed({i_sample_in, {bbbp_pkg::SIG_FRAC{1'b0}}}));
                mul_b   = $signed({1'b0, r_hp_gain});
                prod_we = 1'b1;
            end
            bbbp_pkg::OP_A1: begin
                mul_b   = i_cmd.sel_lp ? r_lp_fb1 : r_hp_fb1;
                prod_we = 1'b1;
            end
            bbbp_pkg::OP_D1: begin
                mul_b   = i_cmd.sel_lp ? r_lp_fb2 : r_hp_fb2;
                prod_we = 1'b1;
            end
            bbbp_pkg::OP_D2: begin
                // highpass output is the lowpass input
                mul_b   = $signed({1'b0, r_lp_gain});
                prod_we = !i_cmd.sel_lp;
            end
            default: prod_we = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign d1_cur = i_cmd.sel_lp ? r_lp_d1 : r_hp_d1;
    assign d2_cur = i_cmd.sel_lp ? r_lp_d2 : r_hp_d2;

    // y = sat(rnd(b0*x) + d1)
    assign sum_y = rnd16(W_ACC'(r_prod)) + W_ACC'(d1_cur);
    assign y_sat = sat32(sum_y);
    assign y_ovf = ovf32(sum_y);

    // d1 = sat(rnd(+-2*b0*x - a1*y) + d2)
    assign p0_x2  = W_ACC'(r_p0) <<< 1;
    assign t_d1   = (i_cmd.sel_lp ? p0_x2 : -p0_x2) - W_ACC'(r_prod);
    assign sum_d1 = rnd16(t_d1) + W_ACC'(d2_cur);
    assign d1_sat = sat32(sum_d1);
    assign d1_ovf = ovf32(sum_d1);

    // d2 = sat(rnd(b0*x - a2*y))
    assign sum_d2 = rnd16(W_ACC'(r_p0) - W_ACC'(r_prod));
    assign d2_sat = sat32(sum_d2);
    assign d2_ovf = ovf32(sum_d2);

    // lowpass y back to sample scale
    assign out_rnd = (W_OUT'(r_y) + OUT_HALF) >>> bbbp_pkg::SIG_FRAC;
    always_comb begin
        out_ovf = 1'b1;
        if (out_rnd > OUT_MAX) begin
            out_sat = OUT_MAX[bbbp_pkg::W_SAMPLE-1:0];
        end else if (out_rnd < OUT_MIN) begin
            out_sat = OUT_MIN[bbbp_pkg::W_SAMPLE-1:0];
        end else begin
            out_sat = out_rnd[bbbp_pkg::W_SAMPLE-1:0];
            out_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_gain <= '0;
            r_hp_fb1  <= '0;
            r_hp_fb2  <= '0;
            r_lp_gain <= '0;
            r_lp_fb1  <= '0;
            r_lp_fb2  <= '0;
            r_hp_d1   <= '0;
            r_hp_d2   <= '0;
            r_lp_d1   <= '0;
            r_lp_d2   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bbbp_pkg::CFG_HP_GAIN: r_hp_gain <= i_cfg_data[bbbp_pkg::W_GAIN-1:0];
                bbbp_pkg::CFG_HP_FB1:  r_hp_fb1  <= $signed(i_cfg_data);
                bbbp_pkg::CFG_HP_FB2:  r_hp_fb2  <= $signed(i_cfg_data);
                bbbp_pkg::CFG_LP_GAIN: r_lp_gain <= i_cfg_data[bbbp_pkg::W_GAIN-1:0];
                bbbp_pkg::CFG_LP_FB1:  r_lp_fb1  <= $signed(i_cfg_data);
                bbbp_pkg::CFG_LP_FB2:  r_lp_fb2  <= $signed(i_cfg_data);
                default: ;
            endcase
            // a write to a register that exists restarts the filter
            if (i_cfg_index <= bbbp_pkg::CFG_LP_FB2) begin
                r_hp_d1 <= '0;
                r_hp_d2 <= '0;
                r_lp_d1 <= '0;
                r_lp_d2 <= '0;
            end
        end else begin
            if (i_cmd.op == bbbp_pkg::OP_D1) begin
                if (i_cmd.sel_lp) r_lp_d1 <= d1_sat;
                else              r_hp_d1 <= d1_sat;
            end
            if (i_cmd.op == bbbp_pkg::OP_D2) begin
                if (i_cmd.sel_lp) r_lp_d2 <= d2_sat;
                else              r_hp_d2 <= d2_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_we) r_prod <= mul_p;
        unique case (i_cmd.op)
            bbbp_pkg::OP_LOAD: r_flag <= 1'b0;
            bbbp_pkg::OP_Y: begin
                r_p0   <= r_prod;
                r_y    <= y_sat;
                r_flag <= r_flag | y_ovf;
            end
            bbbp_pkg::OP_D1: r_flag <= r_flag | d1_ovf;
            bbbp_pkg::OP_D2: begin
                r_flag <= r_flag | d2_ovf;
                if (i_cmd.sel_lp) begin
                    r_sample_out <= out_sat;
                    r_clipped    <= r_flag | d2_ovf | out_ovf;
                end
            end
            default: ;
        endcase
    end

    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

// ===== hw/rtl/butterworth_bandpass_biquad_pair.sv =====
// Each accepted word passes the highpass then lowpass states, the last waiting on output
// stall; input is stalled meanwhile. Six products per word share one 32x18 multiplier,
// three per biquad, each section's feedback products waiting on its own output y.
// Reset (synchronous, active low) zeroes all gains, feedback coefficients and delays,
// so output is silent until configured; a write to indexes 0-5 also clears the delays.
module butterworth_bandpass_biquad_pair (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [bbbp_pkg::W_SAMPLE-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [bbbp_pkg::W_SAMPLE-1:0] o_sample_out,
    output logic                                 o_clipped,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bbbp_pkg::W_CFG_IDX-1:0]       i_cfg_index,
    input  logic [bbbp_pkg::W_CFG_DATA-1:0]      i_cfg_data
);

    bbbp_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    bbbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    bbbp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample_in  (i_sample_in),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

// ===== hw/rtl/bbbp_chk.sv =====
module bbbp_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [bbbp_pkg::W_SAMPLE-1:0] o_sample_out,
    input logic                                 o_clipped
);

    // a held result word keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out) && $stable(o_clipped))
        else $error("result word changed while stalled");

    // the input is still closed when the pass reaches its last state
    a_busy_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##8 o_in_stall)
        else $error("input reopened before the filter pass finished");

    // a new result only appears as the pass completes
    a_rise_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && $past(i_rst_n) |-> !o_in_stall)
        else $error("result appeared while still busy");

    // finishing a pass always leaves a result word
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) && $past(i_rst_n) |-> o_out_valid)
        else $error("pass finished without a result word");

endmodule

bind butterworth_bandpass_biquad_pair bbbp_chk u_chk (.*);

// ===== tb/bandpass_word_checker.sv =====
`timescale 1ns / 1ps

module bandpass_word_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [bbbp_pkg::W_SAMPLE-1:0] i_sample_in,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [bbbp_pkg::W_SAMPLE-1:0] i_sample_out,
    input  logic                                 i_clipped,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [bbbp_pkg::W_CFG_IDX-1:0]       i_cfg_index,
    input  logic [bbbp_pkg::W_CFG_DATA-1:0]      i_cfg_data,
    output int                                   o_pending,
    output int                                   o_errors
);
    import bbbp_pkg::*;

    typedef struct packed {
        logic signed [W_SAMPLE-1:0] sample;
        logic                       clipped;
    } t_band_word;

    localparam int     HP = 0;
    localparam int     LP = 1;
    localparam longint SIG_HI = (64'sd1 <<< (W_SIG - 1)) - 1;
    localparam longint SIG_LO = -(64'sd1 <<< (W_SIG - 1));
    localparam longint OUT_HI = (64'sd1 <<< (W_SAMPLE - 1)) - 1;
    localparam longint OUT_LO = -(64'sd1 <<< (W_SAMPLE - 1));

    // coefficients and delays per section, held as plain integers
    longint     gain [2];
    longint     fb_one [2];
    longint     fb_two [2];
    longint     delay_one [2];
    longint     delay_two [2];
    t_band_word expected_words [$];
    t_band_word due;
    t_band_word fresh;
    int         mismatches = 0;
    int         words_seen = 0;

    assign o_errors = mismatches;

    task automatic note_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic longint clamp_sig(input longint v, inout bit sat);
        if (v > SIG_HI) begin
            sat = 1'b1;
            return SIG_HI;
        end
        if (v < SIG_LO) begin
            sat = 1'b1;
            return SIG_LO;
        end
        return v;
    endfunction

    // nearest, ties upwards
    function automatic longint round_q16(input longint p);
        return (p + 32768) >>> COEF_FRAC;
    endfunction

    // DF2T section; b1 is twice the gain, its sign set by the section type
    task automatic run_biquad(input int s, input longint x, input longint b1_sign,
                              output longint y, inout bit sat);
        longint b1;
        longint n1;
        longint n2;
        b1 = b1_sign * 2 * gain[s];
        y  = clamp_sig(round_q16(gain[s] * x) + delay_one[s], sat);
        n1 = clamp_sig(round_q16(b1 * x - fb_one[s] * y) + delay_two[s], sat);
        n2 = clamp_sig(round_q16(gain[s] * x - fb_two[s] * y), sat);
        delay_one[s] = n1;
        delay_two[s] = n2;
    endtask

    task automatic filter_sample(input logic signed [W_SAMPLE-1:0] s, output t_band_word w);
        longint x;
        longint hp_y;
        longint bp_y;
        longint q;
        bit     sat;
        sat = 1'b0;
        x = s;
        x = x * (64'sd1 <<< SIG_FRAC);
        run_biquad(HP, x, -1, hp_y, sat);
        run_biquad(LP, hp_y, 1, bp_y, sat);
        q = (bp_y + 128) >>> SIG_FRAC;
        if (q > OUT_HI) begin
            q = OUT_HI;
            sat = 1'b1;
        end
        if (q < OUT_LO) begin
            q = OUT_LO;
            sat = 1'b1;
        end
        w.sample  = q[W_SAMPLE-1:0];
        w.clipped = sat;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = HP; s <= LP; s++) begin
                gain[s]      = 0;
                fb_one[s]    = 0;
                fb_two[s]    = 0;
                delay_one[s] = 0;
                delay_two[s] = 0;
            end
            expected_words.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HP_GAIN: gain[HP]   = i_cfg_data[W_GAIN-1:0];
                    CFG_HP_FB1:  fb_one[HP] = $signed(i_cfg_data);
                    CFG_HP_FB2:  fb_two[HP] = $signed(i_cfg_data);
                    CFG_LP_GAIN: gain[LP]   = i_cfg_data[W_GAIN-1:0];
                    CFG_LP_FB1:  fb_one[LP] = $signed(i_cfg_data);
                    CFG_LP_FB2:  fb_two[LP] = $signed(i_cfg_data);
                    default: ;
                endcase
                // spare indexes leave the delays alone
                if (i_cfg_index <= CFG_LP_FB2) begin
                    for (int s = HP; s <= LP; s++) begin
                        delay_one[s] = 0;
                        delay_two[s] = 0;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                filter_sample(i_sample_in, fresh);
                expected_words.push_back(fresh);
            end
            if (i_out_valid && !i_out_stall) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    note_mismatch($sformatf("word %0d arrived with none due (sample %0d)",
                                            words_seen, i_sample_out));
                end else begin
                    due = expected_words.pop_front();
                    if (i_sample_out !== due.sample) begin
                        note_mismatch($sformatf("word %0d sample_out %0d, want %0d",
                                                words_seen, i_sample_out, due.sample));
                    end
                    if (i_clipped !== due.clipped) begin
                        note_mismatch($sformatf("word %0d clipped %b, want %b",
                                                words_seen, i_clipped, due.clipped));
                    end
                end
            end
            o_pending <= expected_words.size();
        end
    end

endmodule

// ===== tb/butterworth_bandpass_biquad_pair_test.sv =====
`timescale 1ns / 1ps

module butterworth_bandpass_biquad_pair_test;
    import bbbp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_WORDS  = 150;
    localparam int RANDOM_PHASES = 8;

    // indexes past the register file
    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef enum logic [1:0] {
        SET_DESIGNED,
        SET_ANY,
        SET_EXTREME,
        SET_MILD
    } t_setting_kind;

    typedef struct {
        int hp_gain;
        int hp_fb1;
        int hp_fb2;
        int lp_gain;
        int lp_fb1;
        int lp_fb2;
    } t_filter_setting;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic signed [W_SAMPLE-1:0]  sample_in = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [W_SAMPLE-1:0]  sample_out;
    logic                        clipped;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [W_CFG_IDX-1:0]        cfg_index = '0;
    logic [W_CFG_DATA-1:0]       cfg_data = '0;
    int                          pending;
    int                          errors;
    int                          cycle_count = 0;
    int                          burst_left = 1;
    t_stall_mode                 stall_mode = STALL_NONE;
    int                          stall_run = 0;

    butterworth_bandpass_biquad_pair i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_sample_in  (sample_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_sample_out (sample_out),
        .o_clipped    (clipped),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    bandpass_word_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_sample_in  (sample_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_sample_out (sample_out),
        .i_clipped    (clipped),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[butterworth_bandpass_biquad_pair] ERROR");
            $finish;
        end
    end

    // receiver back-pressure: a mode is held for a random stretch
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_run  <= $urandom_range(20, 200);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 7) != 0);
            STALL_PERIODIC: out_stall <= ((cycle_count % 13) < 5);
            default:        out_stall <= 1'b0;
        endcase
    end

    task automatic send_sample(input int v);
        int gap;
        in_valid  <= 1'b1;
        sample_in <= v[W_SAMPLE-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold off until every word sent has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx, input int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[W_CFG_DATA-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_filter(input t_filter_setting s);
        write_reg(CFG_HP_GAIN, s.hp_gain);
        write_reg(CFG_HP_FB1, s.hp_fb1);
        write_reg(CFG_HP_FB2, s.hp_fb2);
        write_reg(CFG_LP_GAIN, s.lp_gain);
        write_reg(CFG_LP_FB1, s.lp_fb1);
        write_reg(CFG_LP_FB2, s.lp_fb2);
        cfg_valid <= 1'b0;
    endtask

    function automatic int rand_sample();
        int marks [4] = '{-32768, 32767, 0, -1};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return int'($urandom_range(0, 65535)) - 32768;
            5, 6:          return int'($urandom_range(0, 511)) - 256;
            7:             return marks[$urandom_range(0, 3)];
            default:       return int'($urandom_range(0, 8191)) - 4096;
        endcase
    endfunction

    // feedback pair inside the stability triangle
    function automatic void mild_feedback(output int a1, output int a2);
        int lim;
        a2  = int'($urandom_range(0, 58982)) - 26214;
        lim = ((65536 + a2) * 9) / 10;
        a1  = int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic int any_coef();
        return int'($urandom_range(0, 262143)) - 131072;
    endfunction

    function automatic int any_gain();
        if ($urandom_range(0, 3) == 0) begin
            return int'($urandom_range(0, 262143));
        end
        return int'($urandom_range(0, 65536));
    endfunction

    function automatic t_filter_setting pick_setting(input t_setting_kind kind);
        t_filter_setting s;
        int gain_marks [4] = '{0, 1, 65536, 131071};
        int coef_marks [4] = '{-131072, 131071, 0, -1};
        case (kind)
            SET_DESIGNED: begin
                // 300 Hz / 3 kHz or 1 kHz / 8 kHz band at 48 kHz
                if ($urandom_range(0, 1) == 0) begin
                    s = '{63742, -127433, 61996, 1963, -95305, 37622};
                end else begin
                    s = '{59741, -118969, 54460, 10161, -40645, 15756};
                end
            end
            SET_ANY: begin
                s = '{any_gain(), any_coef(), any_coef(), any_gain(), any_coef(), any_coef()};
            end
            SET_EXTREME: begin
                s.hp_gain = gain_marks[$urandom_range(0, 3)];
                s.hp_fb1  = coef_marks[$urandom_range(0, 3)];
                s.hp_fb2  = coef_marks[$urandom_range(0, 3)];
                s.lp_gain = gain_marks[$urandom_range(0, 3)];
                s.lp_fb1  = coef_marks[$urandom_range(0, 3)];
                s.lp_fb2  = coef_marks[$urandom_range(0, 3)];
            end
            default: begin
                s.hp_gain = $urandom_range(0, 65536);
                s.lp_gain = $urandom_range(0, 65536);
                mild_feedback(s.hp_fb1, s.hp_fb2);
                mild_feedback(s.lp_fb1, s.lp_fb2);
            end
        endcase
        return s;
    endfunction

    initial begin
        t_filter_setting setting;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gains still zero: output silent
        send_sample(0);
        send_sample(32767);
        send_sample(-32768);
        settle();

        // plain FIR sections, 1 -2 1 then 1 2 1: full scale steps clip
        load_filter('{65536, 0, 0, 65536, 0, 0});
        send_sample(32767);
        send_sample(0);
        send_sample(0);
        send_sample(0);
        send_sample(-32768);
        send_sample(1);
        send_sample(-1);
        send_sample(0);
        settle();

        // half gain on the lowpass puts odd samples on a rounding tie
        load_filter('{65536, 0, 0, 32768, 0, 0});
        send_sample(-1);
        send_sample(1);
        send_sample(-3);
        send_sample(3);
        settle();

        // widest gains and feedback: internal sums run into the rails
        load_filter('{131071, -131072, 131071, 131071, 131071, -131072});
        send_sample(32767);
        send_sample(-32768);
        send_sample(32767);
        send_sample(-32768);
        send_sample(0);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            setting = pick_setting(t_setting_kind'(p % 4));
            load_filter(setting);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2) begin
                    // write to a spare index mid-stream: delays must survive
                    settle();
                    write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_B : CFG_SPARE_A,
                              any_coef());
                    cfg_valid <= 1'b0;
                end
                send_sample(rand_sample());
            end
            settle();
        end

        repeat (30) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("[butterworth_bandpass_biquad_pair] OK");
        end else begin
            $display("[butterworth_bandpass_biquad_pair] ERROR");
        end
        $finish;
    end

endmodule
